### rtl/core/cu64acc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cu64acc_pkg: shared types and constants of the checked 64-bit accumulator
// Command, status and sequencer codes, plus the datapath widths.
// ----------------------------------------------------------------------------
package cu64acc_pkg;

   localparam int DATA_W = 64;
   localparam int CMD_W  = 4;
   localparam int STAT_W = 2;
   localparam int ORD_W  = 2;
   // One iteration per operand bit.
   localparam int CNT_W  = $clog2(DATA_W);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 4'd0,
      CMD_ADD  = 4'd1,
      CMD_SUB  = 4'd2,
      CMD_MUL  = 4'd3,
      CMD_DIV  = 4'd4,
      CMD_MOD  = 4'd5,
      CMD_INC  = 4'd6,
      CMD_DEC  = 4'd7,
      CMD_CMP  = 4'd8,
      CMD_NEG  = 4'd9
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_OVERFLOW = 2'd1,
      STAT_LIMIT    = 2'd2,
      STAT_DIVZERO  = 2'd3
   } stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ITER,
      ST_DONE
   } state_type;

   // Compare outcomes, two-bit two's complement.
   localparam logic signed [ORD_W-1:0] ORD_EQ   = 2'sb00;
   localparam logic signed [ORD_W-1:0] ORD_MORE = 2'sb01;
   localparam logic signed [ORD_W-1:0] ORD_LESS = 2'sb11;

endpackage

### rtl/core/checked_uint64_accumulator_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_uint64_accumulator_alu: checked unsigned 64-bit accumulator
// Applies one command per beat to a 64-bit accumulator with a null flag,
// using one shared 65-bit adder for every operation except load.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_ready  command, operand, operand_null
//  rsp_      out        rsp_valid / rsp_ready  value, value_null, status,
//                                              order, negated, negated_valid
//
//  Every command passes the execute and done states; multiply, divide and
//  modulo run the iterate state between them (64 shift-add or restoring
//  subtract steps through the shared adder) unless an operand is null or
//  the divisor is zero. req_ready is high only while the sequencer is idle.
//  A result waiting in the output register does not block the next accept;
//  only a result whose register is still full stalls the sequencer. Reset
//  clears the accumulator to 0, not null, and drops any beat.
// ----------------------------------------------------------------------------
module checked_uint64_accumulator_alu
   import cu64acc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [DATA_W-1:0]        req_operand,
   input  logic                     req_operand_null,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [DATA_W-1:0]        rsp_value,
   output logic                     rsp_value_null,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [ORD_W-1:0]  rsp_order,
   output logic signed [DATA_W-1:0] rsp_negated,
   output logic                     rsp_negated_valid
);

   // control and architectural state
   state_type                state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        acc_ff, acc_in;
   logic                     null_ff, null_in;

   // captured beat and iteration registers
   cmd_type                  cmd_ff, cmd_in;
   logic [DATA_W-1:0]        opd_ff, opd_in;
   logic                     onull_ff, onull_in;
   logic [DATA_W-1:0]        work_ff, work_in;
   logic [DATA_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     ovf_ff, ovf_in;

   // staged result of the current beat
   stat_type                 status_ff, status_in;
   logic signed [ORD_W-1:0]  order_ff, order_in;
   logic [DATA_W-1:0]        neg_ff, neg_in;
   logic                     negv_ff, negv_in;

   // output register
   logic [DATA_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                     rsp_null_ff, rsp_null_in;
   stat_type                 rsp_status_ff, rsp_status_in;
   logic signed [ORD_W-1:0]  rsp_order_ff, rsp_order_in;
   logic [DATA_W-1:0]        rsp_neg_ff, rsp_neg_in;
   logic                     rsp_negv_ff, rsp_negv_in;

   // shared adder / subtractor
   logic [DATA_W:0]          alu_a, alu_b;
   logic                     alu_sub;
   logic [DATA_W+1:0]        alu_sum;
   logic                     alu_carry;   // add: result above 64 bits
   logic                     alu_ge;      // sub: a >= b

   assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {(DATA_W+1){alu_sub}}}
                    + {{(DATA_W+1){1'b0}}, alu_sub};
   assign alu_carry = alu_sum[DATA_W];
   assign alu_ge    = alu_sum[DATA_W+1];

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_value_null    = rsp_null_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_order         = rsp_order_ff;
   assign rsp_negated       = rsp_neg_ff;
   assign rsp_negated_valid = rsp_negv_ff;

   // Register control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         null_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         null_ff      <= null_in;
      end
   end

   // Register payload
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      opd_ff        <= opd_in;
      onull_ff      <= onull_in;
      work_ff       <= work_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      ovf_ff        <= ovf_in;
      status_ff     <= status_in;
      order_ff      <= order_in;
      neg_ff        <= neg_in;
      negv_ff       <= negv_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_null_ff   <= rsp_null_in;
      rsp_status_ff <= rsp_status_in;
      rsp_order_ff  <= rsp_order_in;
      rsp_neg_ff    <= rsp_neg_in;
      rsp_negv_ff   <= rsp_negv_in;
   end

   // Sequence commands through the shared adder
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      acc_in        = acc_ff;
      null_in       = null_ff;
      cmd_in        = cmd_ff;
      opd_in        = opd_ff;
      onull_in      = onull_ff;
      work_in       = work_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      ovf_in        = ovf_ff;
      status_in     = status_ff;
      order_in      = order_ff;
      neg_in        = neg_ff;
      negv_in       = negv_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_null_in   = rsp_null_ff;
      rsp_status_in = rsp_status_ff;
      rsp_order_in  = rsp_order_ff;
      rsp_neg_in    = rsp_neg_ff;
      rsp_negv_in   = rsp_negv_ff;
      alu_a         = '0;
      alu_b         = '0;
      alu_sub       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // capture the request beat
            if (req_valid) begin
               cmd_in   = cmd_type'(req_command);
               opd_in   = req_operand;
               onull_in = req_operand_null;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            status_in = STAT_OK;
            order_in  = ORD_EQ;
            neg_in    = '0;
            negv_in   = 1'b0;
            state_in  = ST_DONE;
            unique case (cmd_ff) inside
               CMD_LOAD: begin
                  acc_in  = onull_ff ? '0 : opd_ff;
                  null_in = onull_ff;
               end
               CMD_ADD: begin
                  alu_a = {1'b0, acc_ff};
                  alu_b = {1'b0, opd_ff};
                  if (null_ff || onull_ff) begin
                     acc_in  = '0;
                     null_in = 1'b1;
                  end else if (alu_carry) begin
                     acc_in    = '0;
                     null_in   = 1'b1;
                     status_in = STAT_OVERFLOW;
                  end else begin
                     acc_in = alu_sum[DATA_W-1:0];
                  end
               end
               CMD_SUB: begin
                  alu_a   = {1'b0, acc_ff};
                  alu_b   = {1'b0, opd_ff};
                  alu_sub = 1'b1;
                  if (null_ff || onull_ff) begin
                     acc_in  = '0;
                     null_in = 1'b1;
                  end else if (!alu_ge) begin
                     acc_in    = '0;
                     null_in   = 1'b1;
                     status_in = STAT_OVERFLOW;
                  end else begin
                     acc_in = alu_sum[DATA_W-1:0];
                  end
               end
               CMD_MUL: begin
                  if (null_ff || onull_ff) begin
                     acc_in  = '0;
                     null_in = 1'b1;
                  end else begin
                     // multiplier bits leave quo from the top
                     work_in  = '0;
                     quo_in   = opd_ff;
                     ovf_in   = 1'b0;
                     cnt_in   = '0;
                     state_in = ST_ITER;
                  end
               end
               CMD_DIV, CMD_MOD: begin
                  if (null_ff || onull_ff) begin
                     acc_in  = '0;
                     null_in = 1'b1;
                  end else if (opd_ff == '0) begin
                     status_in = STAT_DIVZERO;
                  end else begin
                     // dividend shifts out of quo, quotient shifts in
                     work_in  = '0;
                     quo_in   = acc_ff;
                     cnt_in   = '0;
                     state_in = ST_ITER;
                  end
               end
               CMD_INC: begin
                  alu_a = {1'b0, acc_ff};
                  alu_b = {{DATA_W{1'b0}}, 1'b1};
                  if (!null_ff) begin
                     if (alu_carry) begin
                        status_in = STAT_LIMIT;
                     end else begin
                        acc_in = alu_sum[DATA_W-1:0];
                     end
                  end
               end
               CMD_DEC: begin
                  alu_a   = {1'b0, acc_ff};
                  alu_b   = {{DATA_W{1'b0}}, 1'b1};
                  alu_sub = 1'b1;
                  if (!null_ff) begin
                     if (!alu_ge) begin
                        status_in = STAT_LIMIT;
                     end else begin
                        acc_in = alu_sum[DATA_W-1:0];
                     end
                  end
               end
               CMD_CMP: begin
                  alu_a   = {1'b0, acc_ff};
                  alu_b   = {1'b0, opd_ff};
                  alu_sub = 1'b1;
                  if (!null_ff && !onull_ff) begin
                     if (!alu_ge) begin
                        order_in = ORD_LESS;
                     end else if (alu_sum[DATA_W-1:0] != '0) begin
                        order_in = ORD_MORE;
                     end
                  end
               end
               CMD_NEG: begin
                  alu_a   = '0;
                  alu_b   = {1'b0, acc_ff};
                  alu_sub = 1'b1;
                  // fits when the value is at most 2^63
                  if (!null_ff && (!acc_ff[DATA_W-1] || acc_ff[DATA_W-2:0] == '0)) begin
                     neg_in  = alu_sum[DATA_W-1:0];
                     negv_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_ITER: begin
            cnt_in = cnt_ff + 1'b1;
            if (cmd_ff == CMD_MUL) begin
               // shift-add, MSB first; overflow is sticky
               alu_a  = {work_ff, 1'b0};
               alu_b  = quo_ff[DATA_W-1] ? {1'b0, acc_ff} : '0;
               work_in = alu_sum[DATA_W-1:0];
               ovf_in  = ovf_ff || work_ff[DATA_W-1] || alu_carry;
               quo_in  = {quo_ff[DATA_W-2:0], 1'b0};
            end else begin
               // restoring divide step
               alu_a   = {work_ff, quo_ff[DATA_W-1]};
               alu_b   = {1'b0, opd_ff};
               alu_sub = 1'b1;
               work_in = alu_ge ? alu_sum[DATA_W-1:0] : alu_a[DATA_W-1:0];
               quo_in  = {quo_ff[DATA_W-2:0], alu_ge};
            end
            if (&cnt_ff) begin
               state_in = ST_DONE;
               if (cmd_ff == CMD_MUL) begin
                  if (ovf_in) begin
                     acc_in    = '0;
                     null_in   = 1'b1;
                     status_in = STAT_OVERFLOW;
                  end else begin
                     acc_in = work_in;
                  end
               end else if (cmd_ff == CMD_DIV) begin
                  acc_in = quo_in;
               end else begin
                  acc_in = work_in;
               end
            end
         end

         ST_DONE: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = acc_ff;
               rsp_null_in   = null_ff;
               rsp_status_in = status_ff;
               rsp_order_in  = order_ff;
               rsp_neg_in    = neg_ff;
               rsp_negv_in   = negv_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A null accumulator always holds zero value bits
   assert property (@(posedge clock) disable iff (reset)
      null_ff |-> (acc_ff == '0))
      else $error("null accumulator holds nonzero value");

   // An accepted beat goes straight to execution
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted beat did not start execution");

   // The last iteration always hands over to the result stage
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER && (&cnt_ff)) |=> (state_ff == ST_DONE))
      else $error("iteration did not finish after the last step");

   // Overflow status always comes with a null accumulator
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_OVERFLOW) |-> rsp_value_null)
      else $error("overflow reported without null result");

   // A valid negation never carries a compare order or an error status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_negated_valid) |->
         (rsp_order == ORD_EQ && rsp_status == STAT_OK && !rsp_value_null))
      else $error("negation result mixed with other outcomes");

endmodule

### test/cu64acc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cu64acc_result_checker: result checker for the checked 64-bit accumulator
// Watches both channels of the block, predicts each result from its own copy of
// the accumulator and null flag, and compares every result beat with the oldest
// prediction, field by field. Hands its mismatch count and the number of
// predictions still waiting to the testbench top.
// ----------------------------------------------------------------------------
module cu64acc_result_checker
   import cu64acc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [DATA_W-1:0]        req_operand,
   input  logic                     req_operand_null,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [DATA_W-1:0]        rsp_value,
   input  logic                     rsp_value_null,
   input  logic [STAT_W-1:0]        rsp_status,
   input  logic signed [ORD_W-1:0]  rsp_order,
   input  logic signed [DATA_W-1:0] rsp_negated,
   input  logic                     rsp_negated_valid,
   output int                       mismatch_count,
   output int                       outstanding
);

   localparam logic [DATA_W-1:0] ALL_ONES  = '1;
   localparam logic [DATA_W-1:0] SIGN_ONLY = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct {
      logic [DATA_W-1:0]        value;
      logic                     value_null;
      stat_type                 status;
      logic signed [ORD_W-1:0]  order;
      logic signed [DATA_W-1:0] negated;
      logic                     negated_valid;
   } acc_result_type;

   // Predicted accumulator state
   logic [DATA_W-1:0] acc_value = '0;
   logic              acc_null  = 1'b0;
   acc_result_type    pending_results[$];
   int                errors = 0;

   function automatic void make_acc_null();
      acc_value = '0;
      acc_null  = 1'b1;
   endfunction

   // Apply one command to the predicted state and return the result it gives
   function automatic acc_result_type apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [DATA_W-1:0] rhs,
                                                    input logic rhs_null);
      acc_result_type      r;
      logic [DATA_W:0]     wide_sum;
      logic [2*DATA_W-1:0] product;
      r.status        = STAT_OK;
      r.order         = ORD_EQ;
      r.negated       = '0;
      r.negated_valid = 1'b0;
      case (cmd) inside
         CMD_LOAD: begin
            if (rhs_null) begin
               make_acc_null();
            end else begin
               acc_value = rhs;
               acc_null  = 1'b0;
            end
         end
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
            // a null on either side makes the result null, no zero check
            if (acc_null || rhs_null) begin
               make_acc_null();
            end else begin
               case (cmd)
                  CMD_ADD: begin
                     wide_sum = {1'b0, acc_value} + {1'b0, rhs};
                     if (wide_sum[DATA_W]) begin
                        make_acc_null();
                        r.status = STAT_OVERFLOW;
                     end else begin
                        acc_value = wide_sum[DATA_W-1:0];
                     end
                  end
                  CMD_SUB: begin
                     if (acc_value < rhs) begin
                        make_acc_null();
                        r.status = STAT_OVERFLOW;
                     end else begin
                        acc_value = acc_value - rhs;
                     end
                  end
                  CMD_MUL: begin
                     product = {{DATA_W{1'b0}}, acc_value} * {{DATA_W{1'b0}}, rhs};
                     if (|product[2*DATA_W-1:DATA_W]) begin
                        make_acc_null();
                        r.status = STAT_OVERFLOW;
                     end else begin
                        acc_value = product[DATA_W-1:0];
                     end
                  end
                  default: begin
                     if (rhs == '0)
                        r.status = STAT_DIVZERO;
                     else if (cmd == CMD_DIV)
                        acc_value = acc_value / rhs;
                     else
                        acc_value = acc_value % rhs;
                  end
               endcase
            end
         end
         CMD_INC: begin
            if (!acc_null) begin
               if (acc_value == ALL_ONES)
                  r.status = STAT_LIMIT;
               else
                  acc_value = acc_value + 1'b1;
            end
         end
         CMD_DEC: begin
            if (!acc_null) begin
               if (acc_value == '0)
                  r.status = STAT_LIMIT;
               else
                  acc_value = acc_value - 1'b1;
            end
         end
         CMD_CMP: begin
            if (!acc_null && !rhs_null) begin
               if (acc_value < rhs)
                  r.order = ORD_LESS;
               else if (acc_value > rhs)
                  r.order = ORD_MORE;
            end
         end
         CMD_NEG: begin
            if (!acc_null && acc_value <= SIGN_ONLY) begin
               r.negated       = ~acc_value + 1'b1;
               r.negated_valid = 1'b1;
            end
         end
         default: ;
      endcase
      r.value      = acc_null ? '0 : acc_value;
      r.value_null = acc_null;
      return r;
   endfunction

   function automatic int field_differs(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Predict on each request beat, compare on each result beat
   always @(posedge clock) begin : watch_beats
      acc_result_type want;
      if (reset) begin
         acc_value = '0;
         acc_null  = 1'b0;
         pending_results.delete();
      end else begin
         if (req_valid && req_ready)
            pending_results.push_back(apply_command(req_command, req_operand,
                                                    req_operand_null));
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result beat arrived with no prediction waiting");
               errors++;
            end else begin
               want = pending_results.pop_front();
               errors += field_differs("value", want.value, rsp_value);
               errors += field_differs("value_null", DATA_W'(want.value_null),
                                       DATA_W'(rsp_value_null));
               errors += field_differs("status", DATA_W'(want.status),
                                       DATA_W'(rsp_status));
               errors += field_differs("order", DATA_W'(want.order),
                                       DATA_W'(rsp_order));
               errors += field_differs("negated", want.negated, rsp_negated);
               errors += field_differs("negated_valid", DATA_W'(want.negated_valid),
                                       DATA_W'(rsp_negated_valid));
            end
         end
      end
      mismatch_count <= errors;
      outstanding    <= pending_results.size();
   end

endmodule

### test/checked_uint64_accumulator_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_uint64_accumulator_alu_tb: testbench for the checked accumulator
// Drives a directed run over limits, nulls, overflow and divide by zero, then
// random commands in phases with different sender and receiver idling, one of
// them starting with a long receiver hold-off. A side checker predicts and
// compares; this top makes stimulus, runs a watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module checked_uint64_accumulator_alu_tb
   import cu64acc_pkg::*;
;

   localparam logic [DATA_W-1:0] ALL_ONES        = '1;
   localparam logic [DATA_W-1:0] SIGN_ONLY       = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [CMD_W-1:0]  CMD_UNUSED_LAST = '1;
   localparam int ITEMS_PER_PHASE = 381;
   localparam int HOLD_CYCLES     = 300;
   localparam int TAIL_CYCLES     = 80;
   localparam int STALL_LIMIT     = 3000;

   logic                     clock;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_command      = '0;
   logic [DATA_W-1:0]        req_operand      = '0;
   logic                     req_operand_null = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic [DATA_W-1:0]        rsp_value;
   logic                     rsp_value_null;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [ORD_W-1:0]  rsp_order;
   logic signed [DATA_W-1:0] rsp_negated;
   logic                     rsp_negated_valid;

   int                mismatch_count;
   int                outstanding;
   int                send_idle_pct    = 0;
   int                stall_pct        = 0;
   bit                hold_off_pending = 1'b0;
   int                quiet_cycles     = 0;
   logic [DATA_W-1:0] last_operand     = '0;

   checked_uint64_accumulator_alu uut (.*);

   cu64acc_result_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: random stalls, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_pending = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offer one request beat after a random gap and hold it until accepted
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] rhs,
                            input logic rhs_null);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_operand      <= rhs;
      req_operand_null <= rhs_null;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      last_operand = rhs;
   endtask

   // Mix of edge values, small values, wide values and the last operand
   function automatic logic [DATA_W-1:0] random_operand();
      case ($urandom_range(15)) inside
         0:       return '0;
         1, 2:    return DATA_W'($urandom_range(1, 16));
         3, 4:    return DATA_W'($urandom_range(1000));
         5:       return DATA_W'($urandom);
         6, 7:    return {$urandom, $urandom};
         8:       return ALL_ONES - DATA_W'($urandom_range(3));
         9:       return DATA_W'(1) << $urandom_range(DATA_W-1);
         10:      return SIGN_ONLY - 2 + DATA_W'($urandom_range(4));
         11, 12:  return last_operand;
         default: return DATA_W'($urandom_range(16'hFFFF));
      endcase
   endfunction

   task automatic random_beat();
      int               pick;
      logic [CMD_W-1:0] cmd;
      pick = $urandom_range(99);
      if (pick < 18)      cmd = CMD_LOAD;
      else if (pick < 27) cmd = CMD_ADD;
      else if (pick < 36) cmd = CMD_SUB;
      else if (pick < 44) cmd = CMD_MUL;
      else if (pick < 52) cmd = CMD_DIV;
      else if (pick < 60) cmd = CMD_MOD;
      else if (pick < 68) cmd = CMD_INC;
      else if (pick < 76) cmd = CMD_DEC;
      else if (pick < 86) cmd = CMD_CMP;
      else if (pick < 96) cmd = CMD_NEG;
      else                cmd = CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_NEG + 1));
      send_beat(cmd, random_operand(), $urandom_range(99) < 5);
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: limits, nulls, overflow, divide by zero, compare, negate
      send_beat(CMD_LOAD, '0, 1'b0);
      send_beat(CMD_DEC, '0, 1'b0);
      send_beat(CMD_NEG, '0, 1'b0);
      send_beat(CMD_LOAD, ALL_ONES, 1'b0);
      send_beat(CMD_INC, '0, 1'b0);
      send_beat(CMD_ADD, 1, 1'b0);
      send_beat(CMD_INC, '0, 1'b0);
      send_beat(CMD_NEG, '0, 1'b0);
      send_beat(CMD_CMP, 5, 1'b0);
      send_beat(CMD_LOAD, 7, 1'b0);
      send_beat(CMD_DIV, '0, 1'b0);
      send_beat(CMD_MOD, '0, 1'b0);
      send_beat(CMD_CMP, 7, 1'b0);
      send_beat(CMD_CMP, 5, 1'b1);
      send_beat(CMD_CMP, ALL_ONES, 1'b0);
      send_beat(CMD_DIV, 2, 1'b0);
      send_beat(CMD_CMP, 2, 1'b0);
      send_beat(CMD_MOD, ALL_ONES, 1'b0);
      send_beat(CMD_LOAD, ALL_ONES, 1'b1);
      send_beat(CMD_DIV, '0, 1'b0);
      send_beat(CMD_LOAD, SIGN_ONLY, 1'b0);
      send_beat(CMD_NEG, '0, 1'b0);
      send_beat(CMD_INC, '0, 1'b0);
      send_beat(CMD_NEG, '0, 1'b0);
      send_beat(CMD_SUB, ALL_ONES, 1'b0);
      send_beat(CMD_LOAD, 9, 1'b0);
      send_beat(CMD_MUL, ALL_ONES, 1'b0);
      send_beat(CMD_UNUSED_LAST, ALL_ONES, 1'b1);
      send_beat(CMD_ADD, 3, 1'b1);
      wait_drained();

      // Random phases: free flow with a long hold-off, slow sender,
      // slow receiver, both slow
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct    = 0;
               stall_pct        = 0;
               hold_off_pending = 1'b1;
            end
            1: begin
               send_idle_pct = 84;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 84;
            end
            default: begin
               send_idle_pct = 34;
               stall_pct     = 34;
            end
         endcase
         repeat (ITEMS_PER_PHASE) random_beat();
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### checked_uint64_accumulator_alu.f
rtl/core/cu64acc_pkg.sv
rtl/core/checked_uint64_accumulator_alu.sv
test/cu64acc_result_checker.sv
test/checked_uint64_accumulator_alu_tb.sv
